### rtl/brb_pkg.sv
// Shared constants, command codes and the stage record for the broadcast ring buffer.
// No dependencies; imported by the top level.
`default_nettype none
package brb_pkg;

  localparam int DEPTH      = 4096;
  localparam int READERS    = 2;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int RDR_W      = 1;
  localparam int WORD_W     = 32;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef logic [PTR_W-1:0] ptr_t;

  // Status of one access while its memory read completes.
  typedef struct packed {
    logic valid;
    logic accepted;
    logic is_read;
    logic full_res;
    logic empty_for_reader;
  } stage_t;

  // Advance a pointer by one slot, wrapping at the end of the ring.
  function automatic ptr_t ptr_adv(input ptr_t p);
    ptr_t q;
    if (p == PTR_W'(DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + PTR_W'(1);
    end
    return q;
  endfunction

endpackage
`default_nettype wire

### rtl/brb_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module brb_ram #(
  parameter int WIDTH = 32,
  parameter int WORDS = 4096,
  parameter int AW    = $clog2(WORDS)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data unless a new read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/broadcast_ring_buffer_core.sv
// Broadcast ring buffer: one writer, several readers, every reader sees every entry.
// Depends on brb_pkg and brb_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one access word: command selects a
//   write of write_data or a read by the reader named in reader. Output channel
//   (out_valid/out_ready) returns one result word per access: accepted,
//   read_data (0 unless an accepted read), full_res and empty_for_reader, both
//   describing the state after the access.
//   Pointers live in registers and are updated at the accept edge; entries live
//   in a synchronous RAM. A write is stored at the accept edge; a read issues
//   its RAM address at the accept edge and the data returns in the next cycle.
//   The result passes through the RAM-read stage and then the output register
//   before it is presented on the output channel.
//   Throughput: one access per cycle while out_ready is high, set by the single
//   RAM read/write port pair; a write followed at once by a read of the same slot
//   is safe because the write lands in the RAM before the read is sampled.
//   Reset clears the write and read pointers and empties the pipeline; the
//   RAM is not cleared, and readers can only reach slots already written.
//   When out_ready is low the output register and the RAM-read stage fill,
//   then in_ready drops; no word is lost or repeated.
`default_nettype none
module broadcast_ring_buffer_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      command,
  input  wire logic [brb_pkg::RDR_W-1:0] reader,
  input  wire logic [31:0]               write_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           accepted,
  output logic [31:0]                    read_data,
  output logic                           full_res,
  output logic                           empty_for_reader
);
  import brb_pkg::*;

  // Pointer state.
  ptr_t wp;
  ptr_t rp [READERS];
  ptr_t wp_next;
  ptr_t rp_next [READERS];

  // Decode of the current access.
  ptr_t wp_adv;
  ptr_t wp_next_adv;
  logic blocks;
  logic valid_reader;
  logic wr_ok;
  logic rd_ok;
  logic full_next;
  logic empty_next;
  logic fire;

  // RAM-read stage and its result.
  stage_t s1;
  logic [DATA_WIDTH-1:0] ram_q;
  logic s1_move;

  assign fire    = in_valid && in_ready;
  assign s1_move = s1.valid && (!out_valid || out_ready);
  // Take a new word whenever the RAM-read stage is empty or drains this cycle.
  assign in_ready = !s1.valid || s1_move;

  always_comb begin
    wp_adv       = ptr_adv(wp);
    valid_reader = (32'(reader) < 32'(READERS));
    blocks       = 1'b0;
    for (int r = 0; r < READERS; r++) begin
      if (rp[r] == wp_adv) begin
        blocks = 1'b1;
      end
    end

    wr_ok = (command == CMD_WRITE) && !blocks;
    rd_ok = (command == CMD_READ) && valid_reader && (rp[reader] != wp);

    wp_next = wr_ok ? wp_adv : wp;
    for (int r = 0; r < READERS; r++) begin
      rp_next[r] = rp[r];
    end
    if (rd_ok) begin
      rp_next[reader] = ptr_adv(rp[reader]);
    end

    // Status after this access.
    wp_next_adv = ptr_adv(wp_next);
    full_next   = 1'b0;
    for (int r = 0; r < READERS; r++) begin
      if (rp_next[r] == wp_next_adv) begin
        full_next = 1'b1;
      end
    end
    empty_next = !valid_reader || (rp_next[reader] == wp_next);
  end

  // Advance pointers at the accept edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      for (int r = 0; r < READERS; r++) begin
        rp[r] <= '0;
      end
    end else if (fire) begin
      wp <= wp_next;
      for (int r = 0; r < READERS; r++) begin
        rp[r] <= rp_next[r];
      end
    end
  end

  brb_ram #(
    .WIDTH (DATA_WIDTH),
    .WORDS (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (fire && wr_ok),
    .waddr (wp),
    .wdata (DATA_WIDTH'(write_data)),
    .re    (fire && rd_ok),
    .raddr (rp[reader]),
    .rdata (ram_q)
  );

  // RAM-read stage: hold status while the read data settles.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (fire) begin
      s1.valid <= 1'b1;
    end else if (s1_move) begin
      s1.valid <= 1'b0;
    end
    if (fire) begin
      s1.accepted         <= wr_ok || rd_ok;
      s1.is_read          <= rd_ok;
      s1.full_res         <= full_next;
      s1.empty_for_reader <= empty_next;
    end
  end

  // Output register: load from the stage when empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      accepted         <= s1.accepted;
      read_data        <= s1.is_read ? WORD_W'(ram_q) : '0;
      full_res         <= s1.full_res;
      empty_for_reader <= s1.empty_for_reader;
    end
  end

endmodule
`default_nettype wire
